@@ rtl/wat_pkg.sv @@
// Shared types and constants for the windowed average temperature block.
package wat_pkg;

  // Field widths
  localparam int SAMPLE_W = 12;
  localparam int WLEN_W   = 6;
  localparam int CAL_W    = 12;
  localparam int TEMP_W   = 27;
  localparam int AVG_W    = 19;
  // Window sum: at most 63 samples of 4095
  localparam int SUM_W    = 18;

  // Shared divider: 26-bit dividend, 12-bit divisor
  localparam int DIVD_W   = 26;
  localparam int DIVS_W   = 12;

  // Scaling constants
  localparam int CENTI        = 100;
  localparam int SPAN_DEG     = 100;    // 130 C minus 30 C
  localparam int OFFSET_CENTI = 3000;   // 30 C in hundredths

  // avg*330/300 == (avg*11)/10; the /10 is a multiply by ceil(2^27/10) and shift
  localparam int            ADJ_SHIFT = 27;
  localparam int            PROD_W    = 47;
  localparam logic [27:0]   ADJ_MUL   = 28'd147639503;  // 11 * 13421773

  // Configuration port
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam logic [1:0] REG_WINDOW_LEN = 2'd0;
  localparam logic [1:0] REG_CAL_COLD   = 2'd1;
  localparam logic [1:0] REG_CAL_HOT    = 2'd2;

  localparam logic [WLEN_W-1:0] WINDOW_LEN_RST = 6'd1;
  localparam logic [CAL_W-1:0]  CAL_COLD_RST   = 12'd0;
  localparam logic [CAL_W-1:0]  CAL_HOT_RST    = 12'd4095;

  // Controller to datapath
  typedef struct packed {
    logic accept;     // take the item, write the ring, arm the walk
    logic walk;       // read the window, one entry per cycle
    logic div_avg;    // start sum*100 / n
    logic avg_latch;  // capture the average
    logic scale;      // register the 330/300 product
    logic prep;       // form calibrated numerator, start second division
    logic out_load;   // load the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic walk_done;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

@@ rtl/wat_ram.sv @@
// Generic single-port-write, registered-read RAM.
module wat_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/wat_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
module wat_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [wat_pkg::DIVD_W-1:0]   dividend,
  input  logic [wat_pkg::DIVS_W-1:0]   divisor,
  output logic                         done,
  output logic [wat_pkg::DIVD_W-1:0]   quotient
);

  localparam int CNT_W = $clog2(wat_pkg::DIVD_W + 1);

  logic [wat_pkg::DIVD_W-1:0] quo_r, quo_nxt;
  logic [wat_pkg::DIVS_W-1:0] rem_r, rem_nxt;
  logic [wat_pkg::DIVS_W-1:0] div_r;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [wat_pkg::DIVS_W:0]   shifted;
  logic [wat_pkg::DIVS_W:0]   trial;
  logic                       fits;

  // one shift-subtract step
  assign shifted = {rem_r, quo_r[wat_pkg::DIVD_W-1]};
  assign trial   = shifted - {1'b0, div_r};
  assign fits    = shifted >= {1'b0, div_r};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(wat_pkg::DIVD_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[wat_pkg::DIVD_W-2:0], fits};
      rem_nxt = fits ? trial[wat_pkg::DIVS_W-1:0] : shifted[wat_pkg::DIVS_W-1:0];
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // operands
  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      div_r <= divisor;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

@@ rtl/wat_ctrl.sv @@
// Sequencer: walk, average division, scaling, calibration division, output.
module wat_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output wat_pkg::cmd_t cmd,
  input  wat_pkg::sts_t sts
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WALK  = 3'd1;
  localparam logic [2:0] S_DIVA  = 3'd2;
  localparam logic [2:0] S_SCALE = 3'd3;
  localparam logic [2:0] S_PREP  = 3'd4;
  localparam logic [2:0] S_DIVT  = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0] state_r, state_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_WALK;
        end
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (sts.walk_done) begin
          cmd.div_avg = 1'b1;
          state_nxt   = S_DIVA;
        end
      end
      S_DIVA: begin
        if (sts.div_done) begin
          cmd.avg_latch = 1'b1;
          state_nxt     = S_SCALE;
        end
      end
      S_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = S_PREP;
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = S_DIVT;
      end
      S_DIVT: begin
        if (sts.div_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

@@ rtl/wat_dp.sv @@
// Datapath: sample ring, window accumulator, shared divider, scaling, output register.
module wat_dp #(
  parameter int RING_DEPTH = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  wat_pkg::cmd_t                      cmd,
  output wat_pkg::sts_t                      sts,
  input  logic [wat_pkg::SAMPLE_W-1:0]       in_sample,
  input  logic [wat_pkg::WLEN_W-1:0]         window_len,
  input  logic [wat_pkg::CAL_W-1:0]          cal_cold,
  input  logic [wat_pkg::CAL_W-1:0]          cal_hot,
  input  logic                               out_stall,
  output logic                               out_valid,
  output logic signed [wat_pkg::TEMP_W-1:0]  out_temp_centi,
  output logic [wat_pkg::AVG_W-1:0]          out_average_scaled,
  output logic                               out_calib_error
);

  localparam int IW    = $clog2(RING_DEPTH);
  localparam int CW0   = $clog2(RING_DEPTH + 1);
  localparam int CNT_W = (CW0 > wat_pkg::WLEN_W) ? CW0 : wat_pkg::WLEN_W;

  // ring pointers and window walk
  logic [IW-1:0]                 idx_r;
  logic [IW-1:0]                 pos;
  logic [IW-1:0]                 rd_addr_r;
  logic [RING_DEPTH-1:0]         valid_r;
  logic                          vld_rd_r;
  logic                          rd_pend_r;
  logic                          rd_en;
  logic [CNT_W-1:0]              cnt_r;
  logic [CNT_W-1:0]              n_r;
  logic [CNT_W-1:0]              wl_ext;
  logic [CNT_W-1:0]              n_clamped;
  logic [wat_pkg::SAMPLE_W-1:0]  ram_rdata;
  logic [wat_pkg::SUM_W-1:0]     acc_r, acc_nxt;

  // arithmetic
  logic                          div_start;
  logic                          div_done;
  logic [wat_pkg::DIVD_W-1:0]    div_dividend;
  logic [wat_pkg::DIVS_W-1:0]    div_divisor;
  logic [wat_pkg::DIVD_W-1:0]    div_quo;
  logic [wat_pkg::AVG_W-1:0]     avg_r;
  logic [wat_pkg::PROD_W-1:0]    prod_r;
  logic [wat_pkg::AVG_W-1:0]     adj;
  logic [wat_pkg::AVG_W-1:0]     cold_centi;
  logic [wat_pkg::AVG_W:0]       diff;
  logic [wat_pkg::AVG_W:0]       diff_neg;
  logic [wat_pkg::AVG_W-1:0]     mag;
  logic                          neg_r;
  logic                          err_r;
  logic signed [wat_pkg::TEMP_W-1:0] q_signed;
  logic signed [wat_pkg::TEMP_W-1:0] temp_val;

  // output register
  logic                              out_valid_r, out_valid_nxt;
  logic signed [wat_pkg::TEMP_W-1:0] out_temp_r;
  logic [wat_pkg::AVG_W-1:0]         out_avg_r;
  logic                              out_err_r;

  // next write slot, wrapping at the ring depth
  assign pos = (idx_r == IW'(RING_DEPTH - 1)) ? '0 : idx_r + IW'(1);

  // window length clamped to one through the ring depth
  assign wl_ext    = CNT_W'(window_len);
  assign n_clamped = (wl_ext == '0) ? CNT_W'(1) :
                     (wl_ext > CNT_W'(RING_DEPTH)) ? CNT_W'(RING_DEPTH) : wl_ext;

  assign rd_en = cmd.walk && (cnt_r != '0);

  wat_ram #(
    .WIDTH (wat_pkg::SAMPLE_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (cmd.accept),
    .waddr (pos),
    .wdata (in_sample),
    .re    (rd_en),
    .raddr (rd_addr_r),
    .rdata (ram_rdata)
  );

  // accumulate the previous cycle's read; never-written entries count as zero
  always_comb begin
    acc_nxt = acc_r;
    if (cmd.accept) begin
      acc_nxt = '0;
    end else if (rd_pend_r && vld_rd_r) begin
      acc_nxt = acc_r + wat_pkg::SUM_W'(ram_rdata);
    end
  end

  // ring control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r     <= '0;
      valid_r   <= '0;
      rd_pend_r <= 1'b0;
      cnt_r     <= '0;
    end else begin
      rd_pend_r <= rd_en;
      if (cmd.accept) begin
        idx_r        <= pos;
        valid_r[pos] <= 1'b1;
        cnt_r        <= n_clamped;
      end else if (rd_en) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  // walk address steps backward from the newest entry
  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (cmd.accept) begin
      rd_addr_r <= pos;
      n_r       <= n_clamped;
    end else if (rd_en) begin
      rd_addr_r <= (rd_addr_r == '0) ? IW'(RING_DEPTH - 1) : rd_addr_r - IW'(1);
    end
    if (rd_en) begin
      vld_rd_r <= valid_r[rd_addr_r];
    end
  end

  // calibration numerator: |adj - cold*100| * 100, sign kept aside
  assign adj        = prod_r[wat_pkg::ADJ_SHIFT +: wat_pkg::AVG_W];
  assign cold_centi = wat_pkg::AVG_W'(cal_cold) * wat_pkg::AVG_W'(wat_pkg::CENTI);
  assign diff       = {1'b0, adj} - {1'b0, cold_centi};
  assign diff_neg   = -diff;
  assign mag        = diff[wat_pkg::AVG_W] ? diff_neg[wat_pkg::AVG_W-1:0]
                                           : diff[wat_pkg::AVG_W-1:0];

  // divider operand select: average first, calibration second
  assign div_start = cmd.div_avg | cmd.prep;
  always_comb begin
    if (cmd.prep) begin
      div_dividend = wat_pkg::DIVD_W'(mag) * wat_pkg::DIVD_W'(wat_pkg::SPAN_DEG);
      div_divisor  = cal_hot - cal_cold;
    end else begin
      div_dividend = wat_pkg::DIVD_W'(acc_r) * wat_pkg::DIVD_W'(wat_pkg::CENTI);
      div_divisor  = wat_pkg::DIVS_W'(n_r);
    end
  end

  wat_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  // average, 330/300 product, sign and calibration flag
  always_ff @(posedge clk) begin
    if (cmd.avg_latch) begin
      avg_r <= div_quo[wat_pkg::AVG_W-1:0];
    end
    if (cmd.scale) begin
      prod_r <= wat_pkg::PROD_W'(avg_r) * wat_pkg::PROD_W'(wat_pkg::ADJ_MUL);
    end
    if (cmd.prep) begin
      neg_r <= diff[wat_pkg::AVG_W];
      err_r <= !(cal_hot > cal_cold);
    end
  end

  // truncated quotient with sign restored, then the 30 C offset; zero on a calibration error
  assign q_signed = wat_pkg::TEMP_W'(div_quo);
  assign temp_val = err_r ? '0 :
                    (neg_r ? -q_signed : q_signed) + wat_pkg::TEMP_W'(wat_pkg::OFFSET_CENTI);

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_temp_r <= temp_val;
      out_avg_r  <= avg_r;
      out_err_r  <= err_r;
    end
  end

  // status
  assign sts.walk_done = (cnt_r == '0) && !rd_pend_r;
  assign sts.div_done  = div_done;
  assign sts.out_free  = !out_valid_r || !out_stall;

  assign out_valid          = out_valid_r;
  assign out_temp_centi     = out_temp_r;
  assign out_average_scaled = out_avg_r;
  assign out_calib_error    = out_err_r;

endmodule

@@ rtl/windowed_average_temperature_top.sv @@
// Top level: configuration registers, controller and datapath.
// Each sample is written into a ring of RING_DEPTH entries; the newest n samples
// (n = window_len clamped to 1..RING_DEPTH) are averaged times 100, scaled by
// 330/300 and mapped through the two-point calibration to hundredths of a degree,
// with one result item per sample. Each item first reads its n window entries
// through the ring RAM's single read port, then runs two divisions on the one
// bit-per-cycle shared divider. A new sample is taken while the previous result
// still waits in the output register. Ring entries never written since reset
// read as zero through per-entry valid flags, so no clearing pass is needed.
// Registers: window_len at 0x0, cal_cold at 0x4, cal_hot at 0x8.
module windowed_average_temperature_top #(
  parameter int RING_DEPTH = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [wat_pkg::SAMPLE_W-1:0]       in_sample,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [wat_pkg::TEMP_W-1:0]  out_temp_centi,
  output logic [wat_pkg::AVG_W-1:0]          out_average_scaled,
  output logic                               out_calib_error,
  // configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [wat_pkg::ADDR_W-1:0]         paddr,
  input  logic [wat_pkg::DATA_W-1:0]         pwdata,
  output logic [wat_pkg::DATA_W-1:0]         prdata,
  output logic                               pready
);

  logic [wat_pkg::WLEN_W-1:0] window_len_r;
  logic [wat_pkg::CAL_W-1:0]  cal_cold_r;
  logic [wat_pkg::CAL_W-1:0]  cal_hot_r;
  logic                       cfg_wr;
  wat_pkg::cmd_t              cmd;
  wat_pkg::sts_t              sts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_len_r <= wat_pkg::WINDOW_LEN_RST;
      cal_cold_r   <= wat_pkg::CAL_COLD_RST;
      cal_hot_r    <= wat_pkg::CAL_HOT_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        wat_pkg::REG_WINDOW_LEN: window_len_r <= pwdata[wat_pkg::WLEN_W-1:0];
        wat_pkg::REG_CAL_COLD:   cal_cold_r   <= pwdata[wat_pkg::CAL_W-1:0];
        wat_pkg::REG_CAL_HOT:    cal_hot_r    <= pwdata[wat_pkg::CAL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // register reads
  always_comb begin
    case (paddr[3:2])
      wat_pkg::REG_WINDOW_LEN: prdata = wat_pkg::DATA_W'(window_len_r);
      wat_pkg::REG_CAL_COLD:   prdata = wat_pkg::DATA_W'(cal_cold_r);
      wat_pkg::REG_CAL_HOT:    prdata = wat_pkg::DATA_W'(cal_hot_r);
      default:                 prdata = '0;
    endcase
  end

  wat_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  wat_dp #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_sample          (in_sample),
    .window_len         (window_len_r),
    .cal_cold           (cal_cold_r),
    .cal_hot            (cal_hot_r),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_temp_centi     (out_temp_centi),
    .out_average_scaled (out_average_scaled),
    .out_calib_error    (out_calib_error)
  );

  // an accepted item keeps the input side closed while it is worked on
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after item accepted");

  // bad calibration forces zero temperature
  a_err_zero_temp: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_calib_error) |-> (out_temp_centi == '0))
    else $error("calibration error with nonzero temperature");

  // the scaled average never exceeds full-scale times 100
  a_avg_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_average_scaled <= wat_pkg::AVG_W'(409500)))
    else $error("average out of range");

endmodule
